/* hw/rtl/bdi_pkg.sv */
// ----------------------------------------------------------------------------
// bdi_pkg
// Shared constants and types of the barycentric depth interpolator.
// ----------------------------------------------------------------------------
package bdi_pkg;

    localparam int WEIGHT_W    = 20;
    localparam int WEIGHT_FRAC = 16;
    localparam int WEIGHT_MAX  = 524287;
    localparam int WEIGHT_MIN  = -524288;
    localparam int CFG_IDX_W   = 3;
    localparam int DIV_BITS    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_X,
        REG_LEFT_Y,
        REG_MID_X,
        REG_MID_Y,
        REG_RIGHT_X,
        REG_RIGHT_Y,
        REG_VERTEX_DEPTHS
    } cfg_reg_t;

    typedef struct packed {
        logic neg_a;
        logic neg_b;
        logic deg;
    } div_flags_t;

endpackage

/* hw/rtl/bdi_if.sv */
// ----------------------------------------------------------------------------
// bdi_if
// Valid/ready channels for pixel positions and interpolation results.
// ----------------------------------------------------------------------------
interface bdi_pix_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;

    modport source (output valid, px, py, input ready);
    modport sink   (input valid, px, py, output ready);
endinterface

interface bdi_res_if #(parameter int DEPTH_WIDTH = 16);
    import bdi_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [WEIGHT_W-1:0] alpha;
    logic signed [WEIGHT_W-1:0] beta;
    logic signed [WEIGHT_W-1:0] gamma;
    logic [DEPTH_WIDTH-1:0]     depth;
    logic                       degenerate;

    modport source (output valid, alpha, beta, gamma, depth, degenerate, input ready);
    modport sink   (input valid, alpha, beta, gamma, depth, degenerate, output ready);
endinterface

/* hw/rtl/barycentric_depth_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// barycentric_depth_interpolator_unit
// Barycentric weights and interpolated depth of a pixel against a triangle.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless res.ready stalls the pipeline, and returns
// one result per pixel, in order: front stages of differences, cross products
// and setup, the pipelined divider that forms the rounded Q3.16 weights four
// quotient bits per stage, and back stages of sign, saturation and depth
// blend. Every stage holds one beat and moves up when the stage after it is
// empty or moving, so bubbles close up under a stall. Vertex registers are
// written through cfg_we, cfg_index and cfg_data; the user must write them
// only while no pixel is in flight, which the block does not enforce. A
// zero-area triangle returns degenerate with zero weights and depth.
module barycentric_depth_interpolator_unit #(
    parameter int COORD_WIDTH = 16,
    parameter int DEPTH_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bdi_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [((3*DEPTH_WIDTH > COORD_WIDTH) ? 3*DEPTH_WIDTH : COORD_WIDTH)-1:0] cfg_data,
    bdi_pix_if.sink                              pix,
    bdi_res_if.source                            res
);
    import bdi_pkg::*;

    localparam int MW    = 2 * COORD_WIDTH + 2;
    localparam int NUM_W = DIV_BITS * ((MW + WEIGHT_FRAC + 2 + DIV_BITS - 1) / DIV_BITS);
    localparam int DS    = NUM_W / DIV_BITS;
    localparam int NS    = DS + 6;

    logic signed [COORD_WIDTH-1:0] lx_reg, ly_reg, mx_reg, my_reg, rx_reg, ry_reg;
    logic [3*DEPTH_WIDTH-1:0]      depths_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lx_reg     <= '0;
            ly_reg     <= '0;
            mx_reg     <= '0;
            my_reg     <= '0;
            rx_reg     <= '0;
            ry_reg     <= '0;
            depths_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LEFT_X:        lx_reg     <= cfg_data[COORD_WIDTH-1:0];
                REG_LEFT_Y:        ly_reg     <= cfg_data[COORD_WIDTH-1:0];
                REG_MID_X:         mx_reg     <= cfg_data[COORD_WIDTH-1:0];
                REG_MID_Y:         my_reg     <= cfg_data[COORD_WIDTH-1:0];
                REG_RIGHT_X:       rx_reg     <= cfg_data[COORD_WIDTH-1:0];
                REG_RIGHT_Y:       ry_reg     <= cfg_data[COORD_WIDTH-1:0];
                REG_VERTEX_DEPTHS: depths_reg <= cfg_data[3*DEPTH_WIDTH-1:0];
                default:           ;
            endcase
        end
    end

    // pipeline occupancy and per-stage advance
    logic [NS-1:0] valid_reg, valid_next, en;

    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || res.ready;
        for (int i = NS - 2; i >= 0; i--)
            en[i] = !valid_reg[i] || en[i+1];
        for (int i = 0; i < NS; i++)
        begin
            if (!en[i])
                valid_next[i] = valid_reg[i];
            else if (i == 0)
                valid_next[i] = pix.valid;
            else
                valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign pix.ready = en[0];
    assign res.valid = valid_reg[NS-1];

    logic [NUM_W-1:0] num_a, num_b, quo_a, quo_b;
    logic [MW:0]      den;
    div_flags_t       front_flags;
    div_flags_t       flags_reg [DS];

    bdi_front #(.COORD_WIDTH(COORD_WIDTH), .NUM_W(NUM_W)) u_front (
        .clk   (clk),
        .en    (en[2:0]),
        .lx    (lx_reg),
        .ly    (ly_reg),
        .mx    (mx_reg),
        .my    (my_reg),
        .rx    (rx_reg),
        .ry    (ry_reg),
        .px    (pix.px),
        .py    (pix.py),
        .num_a (num_a),
        .num_b (num_b),
        .den   (den),
        .flags (front_flags)
    );

    bdi_div #(.NUM_W(NUM_W), .DEN_W(MW + 1), .STAGES(DS)) u_div_a (
        .clk (clk),
        .en  (en[3 +: DS]),
        .num (num_a),
        .den (den),
        .quo (quo_a)
    );

    bdi_div #(.NUM_W(NUM_W), .DEN_W(MW + 1), .STAGES(DS)) u_div_b (
        .clk (clk),
        .en  (en[3 +: DS]),
        .num (num_b),
        .den (den),
        .quo (quo_b)
    );

    // signs and degenerate flag ride alongside the divider
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DS; s++)
        begin
            if (en[3+s])
                flags_reg[s] <= (s == 0) ? front_flags : flags_reg[(s == 0) ? 0 : s-1];
        end
    end

    bdi_back #(.NUM_W(NUM_W), .DEPTH_WIDTH(DEPTH_WIDTH)) u_back (
        .clk        (clk),
        .en         (en[NS-3 +: 3]),
        .quo_a      (quo_a),
        .quo_b      (quo_b),
        .flags      (flags_reg[DS-1]),
        .depths     (depths_reg),
        .alpha      (res.alpha),
        .beta       (res.beta),
        .gamma      (res.gamma),
        .depth      (res.depth),
        .degenerate (res.degenerate)
    );

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !res.valid |-> pix.ready)
        else $error("input stalled with an empty output stage");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.degenerate |->
            res.alpha == '0 && res.beta == '0 && res.gamma == '0 && res.depth == '0)
        else $error("degenerate result with nonzero outputs");

    a_gamma_one: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.degenerate && res.alpha == '0 && res.beta == '0 |->
            res.gamma == WEIGHT_W'(1 << WEIGHT_FRAC))
        else $error("gamma not one with zero alpha and beta");

endmodule

/* hw/rtl/bdi_front.sv */
// ----------------------------------------------------------------------------
// bdi_front
// Edge differences, cross products and dividend/divisor setup (3 stages).
// ----------------------------------------------------------------------------
module bdi_front #(
    parameter int COORD_WIDTH = 16,
    parameter int NUM_W       = 52
) (
    input  logic                          clk,
    input  logic [2:0]                    en,
    input  logic signed [COORD_WIDTH-1:0] lx,
    input  logic signed [COORD_WIDTH-1:0] ly,
    input  logic signed [COORD_WIDTH-1:0] mx,
    input  logic signed [COORD_WIDTH-1:0] my,
    input  logic signed [COORD_WIDTH-1:0] rx,
    input  logic signed [COORD_WIDTH-1:0] ry,
    input  logic signed [COORD_WIDTH-1:0] px,
    input  logic signed [COORD_WIDTH-1:0] py,
    output logic [NUM_W-1:0]              num_a,
    output logic [NUM_W-1:0]              num_b,
    output logic [2*COORD_WIDTH+2:0]      den,
    output bdi_pkg::div_flags_t           flags
);
    import bdi_pkg::*;

    localparam int DFW = COORD_WIDTH + 1;
    localparam int PW  = 2 * DFW;
    localparam int SW  = PW + 1;
    localparam int MW  = SW - 1;

    logic signed [DFW-1:0] dlx_reg, dly_reg, dmx_reg, dmy_reg, dpx_reg, dpy_reg;
    logic signed [PW-1:0]  pd0_reg, pd1_reg, pa0_reg, pa1_reg, pb0_reg, pb1_reg;
    logic signed [SW-1:0]  det, da, db;
    logic signed [SW-1:0]  det_abs, da_abs, db_abs;
    logic [MW-1:0]         d_mag;
    logic [NUM_W-1:0]      num_a_reg, num_b_reg;
    logic [MW:0]           den_reg;
    div_flags_t            flags_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dlx_reg <= DFW'(lx) - DFW'(rx);
            dly_reg <= DFW'(ly) - DFW'(ry);
            dmx_reg <= DFW'(mx) - DFW'(rx);
            dmy_reg <= DFW'(my) - DFW'(ry);
            dpx_reg <= DFW'(px) - DFW'(rx);
            dpy_reg <= DFW'(py) - DFW'(ry);
        end
        if (en[1])
        begin
            pd0_reg <= PW'(dlx_reg) * PW'(dmy_reg);
            pd1_reg <= PW'(dmx_reg) * PW'(dly_reg);
            pa0_reg <= PW'(dpx_reg) * PW'(dmy_reg);
            pa1_reg <= PW'(dmx_reg) * PW'(dpy_reg);
            pb0_reg <= PW'(dlx_reg) * PW'(dpy_reg);
            pb1_reg <= PW'(dpx_reg) * PW'(dly_reg);
        end
    end

    always_comb
    begin
        det     = SW'(pd0_reg) - SW'(pd1_reg);
        da      = SW'(pa0_reg) - SW'(pa1_reg);
        db      = SW'(pb0_reg) - SW'(pb1_reg);
        det_abs = det[SW-1] ? -det : det;
        da_abs  = da[SW-1] ? -da : da;
        db_abs  = db[SW-1] ? -db : db;
        d_mag   = det_abs[MW-1:0];
    end

    // rounded quotient: (2*n*2^16 + d) / (2*d)
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            num_a_reg       <= NUM_W'({da_abs[MW-1:0], {(WEIGHT_FRAC+1){1'b0}}}) + NUM_W'(d_mag);
            num_b_reg       <= NUM_W'({db_abs[MW-1:0], {(WEIGHT_FRAC+1){1'b0}}}) + NUM_W'(d_mag);
            den_reg         <= {d_mag, 1'b0};
            flags_reg.neg_a <= da[SW-1] ^ det[SW-1];
            flags_reg.neg_b <= db[SW-1] ^ det[SW-1];
            flags_reg.deg   <= (det == '0);
        end
    end

    assign num_a = num_a_reg;
    assign num_b = num_b_reg;
    assign den   = den_reg;
    assign flags = flags_reg;

endmodule

/* hw/rtl/bdi_div.sv */
// ----------------------------------------------------------------------------
// bdi_div
// Pipelined restoring divider, DIV_BITS (four) quotient bits per stage.
// ----------------------------------------------------------------------------
module bdi_div #(
    parameter int NUM_W  = 52,
    parameter int DEN_W  = 35,
    parameter int STAGES = 13
) (
    input  logic              clk,
    input  logic [STAGES-1:0] en,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic [NUM_W-1:0]  quo
);
    import bdi_pkg::*;

    // num register shifts left; quotient bits fill in from the bottom
    logic [NUM_W-1:0] num_reg [STAGES];
    logic [DEN_W-1:0] rem_reg [STAGES];
    logic [DEN_W-1:0] den_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [NUM_W-1:0] num_in, num_next;
        logic [DEN_W-1:0] rem_in, rem_next, den_in;

        if (s == 0)
        begin : g_first
            assign num_in = num;
            assign rem_in = '0;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign num_in = num_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        always_comb
        begin
            logic [DEN_W:0] rem_ext;
            num_next = num_in;
            rem_next = rem_in;
            for (int k = 0; k < DIV_BITS; k++)
            begin
                rem_ext  = {rem_next, num_next[NUM_W-1]};
                num_next = {num_next[NUM_W-2:0], 1'b0};
                if (rem_ext >= {1'b0, den_in})
                begin
                    rem_ext     = rem_ext - {1'b0, den_in};
                    num_next[0] = 1'b1;
                end
                rem_next = rem_ext[DEN_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                num_reg[s] <= num_next;
                rem_reg[s] <= rem_next;
                den_reg[s] <= den_in;
            end
        end
    end

    assign quo = num_reg[STAGES-1];

endmodule

/* hw/rtl/bdi_back.sv */
// ----------------------------------------------------------------------------
// bdi_back
// Weight signs, gamma, saturation and depth blend (3 stages).
// ----------------------------------------------------------------------------
module bdi_back #(
    parameter int NUM_W       = 52,
    parameter int DEPTH_WIDTH = 16
) (
    input  logic                                clk,
    input  logic [2:0]                          en,
    input  logic [NUM_W-1:0]                    quo_a,
    input  logic [NUM_W-1:0]                    quo_b,
    input  bdi_pkg::div_flags_t                 flags,
    input  logic [3*DEPTH_WIDTH-1:0]            depths,
    output logic signed [bdi_pkg::WEIGHT_W-1:0] alpha,
    output logic signed [bdi_pkg::WEIGHT_W-1:0] beta,
    output logic signed [bdi_pkg::WEIGHT_W-1:0] gamma,
    output logic [DEPTH_WIDTH-1:0]              depth,
    output logic                                degenerate
);
    import bdi_pkg::*;

    localparam int GW  = NUM_W + 3;
    localparam int PRW = WEIGHT_W + DEPTH_WIDTH + 1;
    localparam int SMW = PRW + 2;
    localparam logic signed [GW-1:0]  ONE_G  = GW'(1) << WEIGHT_FRAC;
    localparam logic signed [GW-1:0]  W_HI   = GW'(WEIGHT_MAX);
    localparam logic signed [GW-1:0]  W_LO   = GW'(WEIGHT_MIN);
    localparam logic signed [SMW-1:0] HALF   = SMW'(1) << (WEIGHT_FRAC - 1);
    localparam logic signed [SMW-1:0] D_MAX  = SMW'({DEPTH_WIDTH{1'b1}});

    function automatic logic signed [WEIGHT_W-1:0] sat_w(input logic signed [GW-1:0] v);
        logic signed [WEIGHT_W-1:0] r;
        if (v > W_HI)
            r = WEIGHT_W'(WEIGHT_MAX);
        else if (v < W_LO)
            r = WEIGHT_W'(WEIGHT_MIN);
        else
            r = v[WEIGHT_W-1:0];
        return r;
    endfunction

    logic signed [GW-1:0]       ea, eb, sa, sb, sg;
    logic signed [WEIGHT_W-1:0] a_reg, b_reg, g_reg;
    logic                       deg_a_reg, deg_b_reg;
    logic signed [PRW-1:0]      pl_reg, pm_reg, pr_reg;
    logic signed [SMW-1:0]      sum, rnd, shifted;
    logic signed [WEIGHT_W-1:0] alpha_reg, beta_reg, gamma_reg;
    logic [DEPTH_WIDTH-1:0]     depth_reg, depth_next;
    logic                       deg_reg;

    always_comb
    begin
        ea = $signed({3'b000, quo_a});
        eb = $signed({3'b000, quo_b});
        sa = flags.neg_a ? -ea : ea;
        sb = flags.neg_b ? -eb : eb;
        sg = ONE_G - sa - sb;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_reg     <= sat_w(sa);
            b_reg     <= sat_w(sb);
            g_reg     <= sat_w(sg);
            deg_a_reg <= flags.deg;
        end
        if (en[1])
        begin
            pl_reg    <= PRW'(a_reg) * $signed(PRW'({1'b0, depths[DEPTH_WIDTH-1:0]}));
            pm_reg    <= PRW'(b_reg) *
                         $signed(PRW'({1'b0, depths[2*DEPTH_WIDTH-1:DEPTH_WIDTH]}));
            pr_reg    <= PRW'(g_reg) *
                         $signed(PRW'({1'b0, depths[3*DEPTH_WIDTH-1:2*DEPTH_WIDTH]}));
            deg_b_reg <= deg_a_reg;
            alpha_reg <= a_reg;
            beta_reg  <= b_reg;
            gamma_reg <= g_reg;
        end
    end

    always_comb
    begin
        sum     = SMW'(pl_reg) + SMW'(pm_reg) + SMW'(pr_reg);
        rnd     = sum + HALF;
        shifted = rnd >>> WEIGHT_FRAC;
        // negative or zero sum clamps to zero
        if (sum[SMW-1] || (sum == '0))
            depth_next = '0;
        else if (shifted > D_MAX)
            depth_next = '1;
        else
            depth_next = shifted[DEPTH_WIDTH-1:0];
    end

    logic signed [WEIGHT_W-1:0] alpha_out_reg, beta_out_reg, gamma_out_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            deg_reg       <= deg_b_reg;
            alpha_out_reg <= deg_b_reg ? '0 : alpha_reg;
            beta_out_reg  <= deg_b_reg ? '0 : beta_reg;
            gamma_out_reg <= deg_b_reg ? '0 : gamma_reg;
            depth_reg     <= deg_b_reg ? '0 : depth_next;
        end
    end

    assign alpha      = alpha_out_reg;
    assign beta       = beta_out_reg;
    assign gamma      = gamma_out_reg;
    assign depth      = depth_reg;
    assign degenerate = deg_reg;

endmodule
